[hdl/nuas_pkg.sv]
// shared types, command codes and an angle helper for the nearest unblocked angle search
`default_nettype none
package nuas_pkg;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [15:0] HALF_TURN      = 16'd32768;
    localparam logic [10:0] NUDGE_AT_RESET = 11'd104;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INJ,
        S_WAIT,
        S_DONE
    } t_state;

    // candidate angle travelling down the row of cells
    typedef struct packed {
        logic        valid;
        logic        first;
        logic        last;
        logic        blocked;
        logic [15:0] angle;
    } t_cand;

    // outcome of one query as seen by the sequencer
    typedef struct packed {
        logic        done;
        logic        found;
        logic [15:0] angle;
    } t_pick;

    // magnitude of the wrapped signed offset of a from b, 0..32768
    function automatic logic [15:0] wrap_abs(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] d;
        d = a - b;
        if (d > HALF_TURN) begin
            d = 16'd0 - d;
        end
        return d;
    endfunction

endpackage
`default_nettype wire

[hdl/nuas_cell.sv]
// one arc cell: holds an arc and marks candidates that the arc blocks
`default_nettype none
module nuas_cell
    import nuas_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_wr_en,
    input  wire logic [15:0] i_center,
    input  wire logic [15:0] i_width,
    input  wire logic        i_active,
    input  wire t_cand       i_cand,
    output t_cand            o_cand,
    output logic [15:0]      o_center,
    output logic [15:0]      o_width
);

    logic [15:0] r_center;
    logic [15:0] r_width;
    t_cand       r_cand;
    t_cand       n_cand;

    always_comb begin
        n_cand = i_cand;
        if (i_active && (wrap_abs(i_cand.angle, r_center) < r_width)) begin
            n_cand.blocked = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_center <= i_center;
            r_width  <= i_width;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand <= '0;
        end else begin
            r_cand <= n_cand;
        end
    end

    assign o_cand   = r_cand;
    assign o_center = r_center;
    assign o_width  = r_width;

endmodule
`default_nettype wire

[hdl/nuas_pick.sv]
// tail of the row: keeps the nearest free edge of a query, or the preferred angle when it is free
`default_nettype none
module nuas_pick
    import nuas_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cand       i_cand,
    input  wire logic [15:0] i_pref,
    output t_pick            o_pick
);

    logic        r_done;
    logic        r_pref_free;
    logic        r_found;
    logic [15:0] r_best;
    logic [15:0] r_res;
    logic        n_done;
    logic        n_pref_free;
    logic        n_found;
    logic [15:0] n_best;
    logic [15:0] n_res;
    logic [15:0] gap;

    always_comb begin
        n_done      = 1'b0;
        n_pref_free = r_pref_free;
        n_found     = r_found;
        n_best      = r_best;
        n_res       = r_res;
        gap         = wrap_abs(i_cand.angle, i_pref);
        if (i_cand.valid) begin
            if (i_cand.first) begin
                n_pref_free = !i_cand.blocked;
                n_found     = 1'b0;
            end else if (!i_cand.blocked && (!r_found || (gap < r_best))) begin
                n_found = 1'b1;
                n_best  = gap;
                n_res   = i_cand.angle;
            end
            n_done = i_cand.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= 1'b0;
            r_pref_free <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            r_done      <= n_done;
            r_pref_free <= n_pref_free;
            r_found     <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best <= n_best;
        r_res  <= n_res;
    end

    always_comb begin
        o_pick.done  = r_done;
        o_pick.found = r_pref_free || r_found;
        if (r_pref_free) begin
            o_pick.angle = i_pref;
        end else if (r_found) begin
            o_pick.angle = r_res;
        end else begin
            o_pick.angle = 16'd0;
        end
    end

endmodule
`default_nettype wire

[hdl/nearest_unblocked_angle_search.sv]
// top level: arc list as a row of cells, query sequencer and result register
// clear, add and unknown commands: result registered and valid in the cycle after the item is taken
// query: the preferred angle and then both edges of each held arc are injected
// down the cell row into the pick stage; the result is registered when the output is free
// one item in work at a time; a new item is taken once the last result has left
// reset: arc count zero, edge_nudge 104, stored arcs undefined until written
`default_nettype none
module nearest_unblocked_angle_search
    import nuas_pkg::*;
#(
    parameter int MAX_ARCS = 16
)
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [10:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [15:0] i_arc_center,
    input  wire logic [15:0] i_arc_half_width,
    input  wire logic [15:0] i_preferred_angle,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_status,
    output logic             o_found,
    output logic [15:0]      o_result_angle,
    output logic [4:0]       o_arcs_held
);

    localparam int CW = $clog2(MAX_ARCS + 1);
    localparam int IW = (MAX_ARCS > 1) ? $clog2(MAX_ARCS) : 1;

    t_state        r_state;
    t_state        n_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] n_idx;
    logic          r_side;
    logic          n_side;
    logic          r_first;
    logic          n_first;
    logic [15:0]   r_pref;
    logic [15:0]   n_pref;
    logic [10:0]   r_nudge;
    logic          r_out_valid;
    logic          n_out_valid;
    logic          r_status;
    logic          n_status;
    logic          r_found;
    logic          n_found;
    logic [15:0]   r_angle;
    logic [15:0]   n_angle;
    logic [4:0]    r_held;
    logic [4:0]    n_held;

    logic          out_free;
    logic          add_go;
    logic [16:0]   reach;
    t_cand         inj;
    t_pick         pick;

    t_cand         cand    [MAX_ARCS+1];
    logic [15:0]   centers [MAX_ARCS];
    logic [15:0]   widths  [MAX_ARCS];

    assign cand[0] = inj;

    for (genvar k = 0; k < MAX_ARCS; k++) begin : g_cell
        nuas_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_wr_en  (add_go && (r_count == CW'(k))),
            .i_center (i_arc_center),
            .i_width  (i_arc_half_width),
            .i_active (CW'(k) < r_count),
            .i_cand   (cand[k]),
            .o_cand   (cand[k+1]),
            .o_center (centers[k]),
            .o_width  (widths[k])
        );
    end

    nuas_pick u_pick (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cand  (cand[MAX_ARCS]),
        .i_pref  (r_pref),
        .o_pick  (pick)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nudge <= NUDGE_AT_RESET;
        end else if (i_cfg_valid) begin
            r_nudge <= i_cfg_data;
        end
    end

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE) && out_free;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_side      = r_side;
        n_first     = r_first;
        n_pref      = r_pref;
        n_out_valid = r_out_valid && !i_ready;
        n_status    = r_status;
        n_found     = r_found;
        n_angle     = r_angle;
        n_held      = r_held;
        add_go      = 1'b0;
        inj         = '0;
        reach       = {1'b0, widths[r_idx]} + {6'd0, r_nudge};
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_status = 1'b0;
                    n_found  = 1'b0;
                    n_angle  = 16'd0;
                    n_held   = 5'(r_count);
                    unique case (i_cmd)
                        CMD_CLEAR: begin
                            n_count     = '0;
                            n_held      = 5'd0;
                            n_out_valid = 1'b1;
                        end
                        CMD_ADD: begin
                            if (r_count < CW'(MAX_ARCS)) begin
                                add_go  = 1'b1;
                                n_count = r_count + CW'(1);
                                n_held  = 5'(r_count + CW'(1));
                            end else begin
                                n_status = 1'b1;
                            end
                            n_out_valid = 1'b1;
                        end
                        CMD_QUERY: begin
                            n_pref  = i_preferred_angle;
                            n_first = 1'b1;
                            n_idx   = '0;
                            n_side  = 1'b0;
                            n_state = S_INJ;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_INJ: begin
                inj.valid = 1'b1;
                if (r_first) begin
                    inj.first = 1'b1;
                    inj.angle = r_pref;
                    inj.last  = (r_count == '0);
                    n_first   = 1'b0;
                end else begin
                    inj.angle = r_side ? centers[r_idx] + reach[15:0]
                                       : centers[r_idx] - reach[15:0];
                    inj.last  = r_side && ((CW'(r_idx) + CW'(1)) == r_count);
                    if (r_side) begin
                        n_side = 1'b0;
                        n_idx  = r_idx + IW'(1);
                    end else begin
                        n_side = 1'b1;
                    end
                end
                if (inj.last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (pick.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_status    = 1'b0;
                    n_found     = pick.found;
                    n_angle     = pick.angle;
                    n_held      = 5'(r_count);
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_side   <= n_side;
        r_first  <= n_first;
        r_pref   <= n_pref;
        r_status <= n_status;
        r_found  <= n_found;
        r_angle  <= n_angle;
        r_held   <= n_held;
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_found        = r_found;
    assign o_result_angle = r_angle;
    assign o_arcs_held    = r_held;

endmodule
`default_nettype wire
